[hdl/hate_pkg.sv]
// hate_pkg: shared constants, codes and word types of the hashed account transfer engine.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps

package hate_pkg;

    localparam int unsigned TABLE_SLOTS_DEF   = 65536;
    localparam int unsigned ACCOUNT_SLOTS_DEF = 32768;

    localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
    localparam int unsigned FMIX_SHIFT = 33;

    localparam logic [63:0] INIT_BAL_RST = 64'd1000000;
    localparam logic [15:0] LIMIT_RST    = 16'd32768;

    localparam logic [1:0] CFG_INIT_BAL = 2'd0;
    localparam logic [1:0] CFG_LIMIT    = 2'd1;

    localparam logic [1:0] ST_APPLIED = 2'd0;
    localparam logic [1:0] ST_NOFUNDS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [63:0] sender_address;
        logic [63:0] receiver_address;
        logic [31:0] amount;
        logic        end_of_batch;
        logic        same;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [14:0] sender_slot;
        logic [14:0] receiver_slot;
        logic [63:0] sender_balance;
        logic [63:0] receiver_balance;
        logic        batch_done;
    } t_result;

endpackage

[hdl/hate_hash.sv]
// hate_hash: iterative fmix64 with one shared 32x32 multiplier, then reduction to a table index.
// Depends on hate_pkg.
`timescale 1ns / 1ps

module hate_hash #(
    parameter int unsigned TABLE_SLOTS = hate_pkg::TABLE_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [63:0]                    i_key,
    output logic                           o_done,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_index
);
    localparam int unsigned TW   = $clog2(TABLE_SLOTS);
    localparam bit          POW2 = ((1 << TW) == TABLE_SLOTS);
    localparam int unsigned YW   = TW + 16;
    // reciprocal for the 16-bit reduction steps; quotient estimate is low by at most two
    localparam logic [17:0]   RECIP = 18'((64'd1 << (TW + 17)) / 64'(TABLE_SLOTS));
    localparam logic [TW+1:0] MOD1  = (TW + 2)'(TABLE_SLOTS);
    localparam logic [TW+1:0] MOD2  = (TW + 2)'(2 * TABLE_SLOTS);

    localparam logic [1:0] H_IDLE = 2'd0;
    localparam logic [1:0] H_MUL  = 2'd1;
    localparam logic [1:0] H_MOD  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [1:0]    r_ph, n_ph;
    logic          r_round, n_round;
    logic [63:0]   r_k, n_k;
    logic [63:0]   r_acc, n_acc;
    logic [1:0]    r_chunk, n_chunk;
    logic [YW-1:0] r_y, n_y;
    logic [16:0]   r_q, n_q;
    logic [TW+1:0] r_r, n_r;
    logic [TW-1:0] r_rem, n_rem;
    logic          r_done, n_done;
    logic [TW-1:0] r_index, n_index;

    logic [63:0] w_b;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    logic [63:0] w_sum;
    logic [34:0] w_qprod;
    logic [YW-1:0] w_qm;
    logic [YW-1:0] w_diff;

    assign w_b = r_round ? hate_pkg::FMIX_C2 : hate_pkg::FMIX_C1;

    always_comb begin
        case (r_ph)
            2'd0: begin w_ma = r_k[31:0];  w_mb = w_b[31:0];  end
            2'd1: begin w_ma = r_k[31:0];  w_mb = w_b[63:32]; end
            default: begin w_ma = r_k[63:32]; w_mb = w_b[31:0]; end
        endcase
    end

    assign w_prod  = 64'(w_ma) * 64'(w_mb);
    assign w_sum   = r_acc + {w_prod[31:0], 32'd0};
    assign w_qprod = 35'(r_y[YW-1:TW-1]) * 35'(RECIP);
    assign w_qm    = YW'(r_q) * YW'(TABLE_SLOTS);
    assign w_diff  = r_y - w_qm;

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_round = r_round;
        n_k     = r_k;
        n_acc   = r_acc;
        n_chunk = r_chunk;
        n_y     = r_y;
        n_q     = r_q;
        n_r     = r_r;
        n_rem   = r_rem;
        n_done  = 1'b0;
        n_index = r_index;
        case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    n_k     = i_key ^ (i_key >> hate_pkg::FMIX_SHIFT);
                    n_ph    = 2'd0;
                    n_round = 1'b0;
                    n_state = H_MUL;
                end
            end
            H_MUL: begin
                case (r_ph)
                    2'd0: begin
                        n_acc = w_prod;
                        n_ph  = 2'd1;
                    end
                    2'd1: begin
                        n_acc = w_sum;
                        n_ph  = 2'd2;
                    end
                    default: begin
                        n_k  = w_sum ^ (w_sum >> hate_pkg::FMIX_SHIFT);
                        n_ph = 2'd0;
                        if (!r_round) begin
                            n_round = 1'b1;
                        end else if (POW2) begin
                            n_index = n_k[TW-1:0];
                            n_done  = 1'b1;
                            n_state = H_IDLE;
                        end else begin
                            n_rem   = '0;
                            n_chunk = 2'd0;
                            n_state = H_MOD;
                        end
                    end
                endcase
            end
            H_MOD: begin
                case (r_ph)
                    2'd0: begin
                        n_y  = {r_rem, r_k[63:48]};
                        n_k  = {r_k[47:0], 16'd0};
                        n_ph = 2'd1;
                    end
                    2'd1: begin
                        n_q  = w_qprod[34:18];
                        n_ph = 2'd2;
                    end
                    2'd2: begin
                        n_r  = w_diff[TW+1:0];
                        n_ph = 2'd3;
                    end
                    default: begin
                        n_rem   = (r_r >= MOD2) ? TW'(r_r - MOD2) :
                                  (r_r >= MOD1) ? TW'(r_r - MOD1) : r_r[TW-1:0];
                        n_ph    = 2'd0;
                        n_chunk = r_chunk + 2'd1;
                        if (r_chunk == 2'd3) begin
                            n_index = n_rem;
                            n_done  = 1'b1;
                            n_state = H_IDLE;
                        end
                    end
                endcase
            end
            default: n_state = H_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_ph    <= n_ph;
        r_round <= n_round;
        r_k     <= n_k;
        r_acc   <= n_acc;
        r_chunk <= n_chunk;
        r_y     <= n_y;
        r_q     <= n_q;
        r_r     <= n_r;
        r_rem   <= n_rem;
        r_index <= n_index;
    end

    assign o_done  = r_done;
    assign o_index = r_index;

endmodule

[hdl/hate_front.sv]
// hate_front: accepts transfer words, marks same-address transfers, queues two words for the back.
// Depends on hate_pkg.
`timescale 1ns / 1ps

module hate_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_ready_init,
    input  logic [63:0]           i_sender_address,
    input  logic [63:0]           i_receiver_address,
    input  logic [31:0]           i_amount,
    input  logic                  i_end_of_batch,
    input  logic                  i_pop,
    output logic                  o_busy,
    output logic                  o_valid,
    output hate_pkg::t_item       o_item
);
    hate_pkg::t_item r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            w_push, w_pop;
    hate_pkg::t_item w_in;

    assign o_busy  = (r_cnt == 2'd2) || !i_ready_init;
    assign w_push  = i_start && !o_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = i_pop && o_valid;
    assign o_item  = r_q[r_rp];

    always_comb begin
        w_in.sender_address   = i_sender_address;
        w_in.receiver_address = i_receiver_address;
        w_in.amount           = i_amount;
        w_in.end_of_batch     = i_end_of_batch;
        w_in.same             = (i_sender_address == i_receiver_address);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end

endmodule

[hdl/hate_back.sv]
// hate_back: sequencer that probes the hash table, creates accounts and moves balances.
// Depends on hate_pkg and hate_hash; holds the slot and balance memories.
`timescale 1ns / 1ps

module hate_back #(
    parameter int unsigned TABLE_SLOTS   = hate_pkg::TABLE_SLOTS_DEF,
    parameter int unsigned ACCOUNT_SLOTS = hate_pkg::ACCOUNT_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [63:0]       i_initial_balance,
    input  logic [15:0]       i_account_limit,
    input  logic              i_valid,
    input  hate_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_ready_init,
    output hate_pkg::t_result o_res
);
    localparam int unsigned TW = $clog2(TABLE_SLOTS);
    localparam int unsigned AW = $clog2(ACCOUNT_SLOTS);
    localparam int unsigned XW = (AW > TW) ? AW : TW;
    localparam int unsigned MW = (XW + 2 > 17) ? XW + 2 : 17;
    localparam int unsigned SW = AW + 65;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HASH   = 4'd2;
    localparam logic [3:0] S_RD     = 4'd3;
    localparam logic [3:0] S_CHK    = 4'd4;
    localparam logic [3:0] S_FULL   = 4'd5;
    localparam logic [3:0] S_MK_S   = 4'd6;
    localparam logic [3:0] S_MK_R   = 4'd7;
    localparam logic [3:0] S_RDB_S  = 4'd8;
    localparam logic [3:0] S_RDB_R  = 4'd9;
    localparam logic [3:0] S_CALC   = 4'd10;
    localparam logic [3:0] S_WR_S   = 4'd11;
    localparam logic [3:0] S_WR_R   = 4'd12;

    localparam logic [1:0] P_SND = 2'd0;
    localparam logic [1:0] P_RCV = 2'd1;
    localparam logic [1:0] P_RE  = 2'd2;

    localparam logic [TW-1:0] TLAST = TW'(TABLE_SLOTS - 1);

    logic [SW-1:0] r_slot_mem [TABLE_SLOTS];
    logic [63:0]   r_bal_mem  [ACCOUNT_SLOTS];
    logic [SW-1:0] r_slot_q;
    logic [63:0]   r_bal_q;

    logic [3:0]    r_state, n_state;
    logic [1:0]    r_phase, n_phase;
    logic [TW-1:0] r_clr, n_clr;
    hate_pkg::t_item r_item, n_item;
    logic [TW-1:0] r_h, n_h;
    logic [TW-1:0] r_n, n_n;
    logic [TW-1:0] r_r_hash, n_r_hash;
    logic          r_s_found, n_s_found, r_r_found, n_r_found;
    logic [AW-1:0] r_s_acct, n_s_acct, r_r_acct, n_r_acct;
    logic [TW-1:0] r_s_pos, n_s_pos, r_r_pos, n_r_pos;
    logic [AW:0]   r_count, n_count;
    logic [63:0]   r_bs, n_bs, r_new_s, n_new_s, r_new_r, n_new_r;
    logic          r_ok, n_ok;
    hate_pkg::t_result r_res, n_res;

    logic          w_hstart, w_hdone;
    logic [TW-1:0] w_hidx;
    logic [63:0]   w_key;
    logic [63:0]   w_hkey;

    logic          w_slot_we;
    logic [TW-1:0] w_slot_wa;
    logic [SW-1:0] w_slot_wd;
    logic          w_bal_we;
    logic [AW-1:0] w_bal_wa, w_bal_ra;
    logic [63:0]   w_bal_wd;

    logic          w_used;
    logic [63:0]   w_skey;
    logic [AW-1:0] w_sacct;
    logic [MW-1:0] w_lim, w_need_tot;
    logic [31:0]   w_s32, w_r32;
    logic [AW-1:0] w_cnt_a;

    assign w_used  = r_slot_q[SW-1];
    assign w_skey  = r_slot_q[AW+63:AW];
    assign w_sacct = r_slot_q[AW-1:0];
    assign w_key   = (r_phase == P_SND) ? r_item.sender_address : r_item.receiver_address;
    // sender hash starts on the pop, receiver hash after the sender probe
    assign w_hkey  = (r_state == S_IDLE) ? i_item.sender_address : r_item.receiver_address;
    assign w_cnt_a = r_count[AW-1:0];
    assign w_s32   = 32'(r_s_acct);
    assign w_r32   = 32'(r_r_acct);

    always_comb begin
        w_lim = MW'(i_account_limit);
        if (w_lim > MW'(ACCOUNT_SLOTS)) begin
            w_lim = MW'(ACCOUNT_SLOTS);
        end
        if (w_lim > MW'(TABLE_SLOTS)) begin
            w_lim = MW'(TABLE_SLOTS);
        end
        w_need_tot = MW'(r_count) + MW'(!r_s_found)
                   + MW'(!r_item.same && !r_r_found);
    end

    hate_hash #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hstart),
        .i_key   (w_hkey),
        .o_done  (w_hdone),
        .o_index (w_hidx)
    );

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_clr     = r_clr;
        n_item    = r_item;
        n_h       = r_h;
        n_n       = r_n;
        n_r_hash  = r_r_hash;
        n_s_found = r_s_found;
        n_r_found = r_r_found;
        n_s_acct  = r_s_acct;
        n_r_acct  = r_r_acct;
        n_s_pos   = r_s_pos;
        n_r_pos   = r_r_pos;
        n_count   = r_count;
        n_bs      = r_bs;
        n_new_s   = r_new_s;
        n_new_r   = r_new_r;
        n_ok      = r_ok;
        n_res     = r_res;
        n_res.valid = 1'b0;
        o_pop     = 1'b0;
        w_hstart  = 1'b0;
        w_slot_we = 1'b0;
        w_slot_wa = r_clr;
        w_slot_wd = '0;
        w_bal_we  = 1'b0;
        w_bal_wa  = w_cnt_a;
        w_bal_wd  = i_initial_balance;
        w_bal_ra  = r_s_acct;
        case (r_state)
            S_CLEAR: begin
                w_slot_we = 1'b1;
                n_clr     = r_clr + TW'(1);
                if (r_clr == TLAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_item  = i_item;
                    n_phase = P_SND;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (w_hdone) begin
                    n_h     = w_hidx;
                    n_n     = '0;
                    n_state = S_RD;
                    if (r_phase == P_RCV) begin
                        n_r_hash = w_hidx;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!w_used || w_skey == w_key || r_n == TLAST) begin
                    if (r_phase == P_SND) begin
                        n_s_found = w_used && (w_skey == w_key);
                        n_s_acct  = w_sacct;
                        n_s_pos   = r_h;
                        if (r_item.same) begin
                            n_state = S_FULL;
                        end else begin
                            n_phase  = P_RCV;
                            w_hstart = 1'b1;
                            n_state  = S_HASH;
                        end
                    end else begin
                        n_r_found = w_used && (w_skey == w_key);
                        n_r_acct  = w_sacct;
                        n_r_pos   = r_h;
                        n_state   = (r_phase == P_RE) ? S_MK_R : S_FULL;
                    end
                end else begin
                    n_h     = (r_h == TLAST) ? '0 : r_h + TW'(1);
                    n_n     = r_n + TW'(1);
                    n_state = S_RD;
                end
            end
            S_FULL: begin
                if (w_need_tot > w_lim) begin
                    n_res.valid            = 1'b1;
                    n_res.status           = hate_pkg::ST_FULL;
                    n_res.sender_slot      = '0;
                    n_res.receiver_slot    = '0;
                    n_res.sender_balance   = '0;
                    n_res.receiver_balance = '0;
                    n_res.batch_done       = r_item.end_of_batch;
                    n_state                = S_IDLE;
                end else begin
                    n_state = S_MK_S;
                end
            end
            S_MK_S: begin
                if (!r_s_found) begin
                    w_slot_we = 1'b1;
                    w_slot_wa = r_s_pos;
                    w_slot_wd = {1'b1, r_item.sender_address, w_cnt_a};
                    w_bal_we  = 1'b1;
                    n_s_acct  = w_cnt_a;
                    n_s_found = 1'b1;
                    n_count   = r_count + (AW + 1)'(1);
                end
                if (r_item.same) begin
                    n_r_acct = n_s_acct;
                    n_state  = S_RDB_S;
                end else if (r_r_found) begin
                    n_state = S_RDB_S;
                end else if (r_s_found) begin
                    n_state = S_MK_R;
                end else begin
                    n_phase = P_RE;
                    n_h     = r_r_hash;
                    n_n     = '0;
                    n_state = S_RD;
                end
            end
            S_MK_R: begin
                if (!r_r_found) begin
                    w_slot_we = 1'b1;
                    w_slot_wa = r_r_pos;
                    w_slot_wd = {1'b1, r_item.receiver_address, w_cnt_a};
                    w_bal_we  = 1'b1;
                    n_r_acct  = w_cnt_a;
                    n_count   = r_count + (AW + 1)'(1);
                end
                n_state = S_RDB_S;
            end
            S_RDB_S: begin
                w_bal_ra = r_s_acct;
                n_state  = S_RDB_R;
            end
            S_RDB_R: begin
                w_bal_ra = r_r_acct;
                n_bs     = r_bal_q;
                n_state  = S_CALC;
            end
            S_CALC: begin
                n_ok = (r_bs >= 64'(r_item.amount));
                if (n_ok) begin
                    n_new_s = r_item.same ? r_bs : r_bs - 64'(r_item.amount);
                    n_new_r = r_item.same ? r_bs : r_bal_q + 64'(r_item.amount);
                end else begin
                    n_new_s = r_bs;
                    n_new_r = r_item.same ? r_bs : r_bal_q;
                end
                n_state = S_WR_S;
            end
            S_WR_S: begin
                w_bal_we = r_ok;
                w_bal_wa = r_s_acct;
                w_bal_wd = r_new_s;
                n_state  = S_WR_R;
            end
            S_WR_R: begin
                w_bal_we = r_ok;
                w_bal_wa = r_r_acct;
                w_bal_wd = r_new_r;
                n_res.valid            = 1'b1;
                n_res.status           = r_ok ? hate_pkg::ST_APPLIED : hate_pkg::ST_NOFUNDS;
                n_res.sender_slot      = w_s32[14:0];
                n_res.receiver_slot    = w_r32[14:0];
                n_res.sender_balance   = r_new_s;
                n_res.receiver_balance = r_new_r;
                n_res.batch_done       = r_item.end_of_batch;
                n_state                = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_IDLE && i_valid) begin
            w_hstart = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_slot_mem[w_slot_wa] <= w_slot_wd;
        end
        r_slot_q <= r_slot_mem[r_h];
        if (w_bal_we) begin
            r_bal_mem[w_bal_wa] <= w_bal_wd;
        end
        r_bal_q <= r_bal_mem[w_bal_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_count   <= '0;
            r_res.valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_count   <= n_count;
            r_res.valid <= n_res.valid;
        end
        r_phase   <= n_phase;
        r_item    <= n_item;
        r_h       <= n_h;
        r_n       <= n_n;
        r_r_hash  <= n_r_hash;
        r_s_found <= n_s_found;
        r_r_found <= n_r_found;
        r_s_acct  <= n_s_acct;
        r_r_acct  <= n_r_acct;
        r_s_pos   <= n_s_pos;
        r_r_pos   <= n_r_pos;
        r_bs      <= n_bs;
        r_new_s   <= n_new_s;
        r_new_r   <= n_new_r;
        r_ok      <= n_ok;
        r_res.status           <= n_res.status;
        r_res.sender_slot      <= n_res.sender_slot;
        r_res.receiver_slot    <= n_res.receiver_slot;
        r_res.sender_balance   <= n_res.sender_balance;
        r_res.receiver_balance <= n_res.receiver_balance;
        r_res.batch_done       <= n_res.batch_done;
    end

    assign o_ready_init = (r_state != S_CLEAR);
    assign o_res        = r_res;

endmodule

[hdl/hashed_account_transfer_engine.sv]
// hashed_account_transfer_engine: top level; configuration registers, front queue, back sequencer.
// Depends on hate_pkg, hate_front, hate_back (and hate_hash below it).
//
//  channel  | handshake                  | words
//  ---------+----------------------------+--------------------------------------------
//  transfer | i_start / o_busy           | sender, receiver, amount, end_of_batch
//  result   | o_result_valid, one cycle  | status, slots, balances, batch_done
//  config   | i_cfg_we, i_cfg_index      | i_cfg_data (0 initial balance, 1 limit)
//
// A transfer is popped, then each lookup hashes its address (fmix64 loop on the shared 32x32
// multiplier, plus a modular reduction when TABLE_SLOTS is not a power of two) and probes the
// table slot by slot; a capacity check, account creation and balance update follow, with a
// receiver re-probe when both accounts are new. The result is registered.
// After reset the slot table is cleared with o_busy high.
// A two-word queue takes transfers while the back works; results cannot be stalled.
`timescale 1ns / 1ps

module hashed_account_transfer_engine #(
    parameter int unsigned TABLE_SLOTS   = hate_pkg::TABLE_SLOTS_DEF,
    parameter int unsigned ACCOUNT_SLOTS = hate_pkg::ACCOUNT_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [63:0] i_sender_address,
    input  logic [63:0] i_receiver_address,
    input  logic [31:0] i_amount,
    input  logic        i_end_of_batch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic [14:0] o_sender_slot,
    output logic [14:0] o_receiver_slot,
    output logic [63:0] o_sender_balance,
    output logic [63:0] o_receiver_balance,
    output logic        o_batch_done
);
    logic [63:0] r_initial_balance;
    logic [15:0] r_account_limit;

    logic              w_ready_init, w_valid, w_pop;
    hate_pkg::t_item   w_item;
    hate_pkg::t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_balance <= hate_pkg::INIT_BAL_RST;
            r_account_limit   <= hate_pkg::LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hate_pkg::CFG_INIT_BAL: r_initial_balance <= i_cfg_data;
                hate_pkg::CFG_LIMIT:    r_account_limit   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    hate_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (i_start),
        .i_ready_init       (w_ready_init),
        .i_sender_address   (i_sender_address),
        .i_receiver_address (i_receiver_address),
        .i_amount           (i_amount),
        .i_end_of_batch     (i_end_of_batch),
        .i_pop              (w_pop),
        .o_busy             (o_busy),
        .o_valid            (w_valid),
        .o_item             (w_item)
    );

    hate_back #(
        .TABLE_SLOTS   (TABLE_SLOTS),
        .ACCOUNT_SLOTS (ACCOUNT_SLOTS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_initial_balance (r_initial_balance),
        .i_account_limit   (r_account_limit),
        .i_valid           (w_valid),
        .i_item            (w_item),
        .o_pop             (w_pop),
        .o_ready_init      (w_ready_init),
        .o_res             (w_res)
    );

    assign o_result_valid     = w_res.valid;
    assign o_status           = w_res.status;
    assign o_sender_slot      = w_res.sender_slot;
    assign o_receiver_slot    = w_res.receiver_slot;
    assign o_sender_balance   = w_res.sender_balance;
    assign o_receiver_balance = w_res.receiver_balance;
    assign o_batch_done       = w_res.batch_done;

`ifndef NO_ASSERTIONS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid) else $error("result strobe held");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == hate_pkg::ST_FULL) |->
        (o_sender_slot == 15'd0 && o_receiver_slot == 15'd0 &&
         o_sender_balance == 64'd0 && o_receiver_balance == 64'd0))
        else $error("full result not zeroed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_status == hate_pkg::ST_APPLIED ||
                            o_status == hate_pkg::ST_NOFUNDS ||
                            o_status == hate_pkg::ST_FULL))
        else $error("bad status");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_busy) else $error("not busy while clearing");
`endif

endmodule
